### sv/mbet_pkg.sv
package mbet_pkg;

   // Field and datapath widths
   localparam int COORD_W    = 14;
   localparam int COUNT_W    = 16;
   localparam int COLOR_W    = 8;
   localparam int C_W        = 32;
   localparam int Z_W        = 36;
   localparam int MAG_W      = 32;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int FRAC_BITS  = 28;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_REAL = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_IMAG = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_REAL   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_IMAG   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIMIT_COUNT = 3'd4;

   localparam logic [C_W-1:0]     ORIGIN_REAL_RST = 32'hD800_0000;
   localparam logic [C_W-1:0]     ORIGIN_IMAG_RST = 32'hE000_0000;
   localparam logic [C_W-1:0]     STEP_REAL_RST   = 32'h0010_0000;
   localparam logic [C_W-1:0]     STEP_IMAG_RST   = 32'h0010_0000;
   localparam logic [COUNT_W-1:0] LIMIT_COUNT_RST = 16'd200;

   // Escape threshold: 4.0 with 28 fraction bits
   localparam logic [Z_W:0] ESCAPE_LIMIT = (Z_W+1)'(64'd4 << FRAC_BITS);

   // Palette: gradient entries, then the interior colour in the last entry
   localparam int PALETTE_SIZE = 16;
   localparam int PAL_IDX_W    = $clog2(PALETTE_SIZE);

   typedef logic [3*COLOR_W-1:0] rgb_type;

   localparam rgb_type PALETTE [PALETTE_SIZE+1] = '{
      24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
      24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
      24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
      24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403,
      24'h101010
   };

endpackage

### sv/mandelbrot_escape_time_pixel_core.sv
// Mandelbrot escape-time pixel core. Each request carries one pixel column and row; the
// core forms c = origin + index * step (Q4.28, saturated), snaps c_imag to zero when it
// lies within half a row step of the axis, and iterates z = z*z + c until |z|^2 >= 4.0 or
// limit_count iterations are done. A request passes through a setup multiply state and
// a setup add state, then N + 1 rounds of a multiply state and an escape test for N
// iterations. Three 32x32 multipliers are shared: they form index * |step| in the setup
// multiply state and the complex square of z in each later multiply state, between
// forming the new z and the escape test. Request ready is high only while no pixel is
// being worked on, so a new pixel is taken only after the last one has finished. The
// finished response sits in an output register, so the next request may be taken while
// it waits; a pixel that finishes while that register is still full holds until it drains.
module mandelbrot_escape_time_pixel_core (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: pixel_x [13:0], pixel_y [27:14], zero fill [31:28]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,
   // tdata: iteration_count [15:0], red [23:16], green [31:24], blue [39:32],
   //        echo_x [53:40], echo_y [67:54], zero fill [71:68]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [71:0]                         rsp_tdata,
   input  logic                                csr_we,
   input  logic [mbet_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [mbet_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL_C = 3'd1;
   localparam logic [2:0] S_ADD_C = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_CHK   = 3'd4;

   localparam int CW  = mbet_pkg::C_W;
   localparam int ZW  = mbet_pkg::Z_W;
   localparam int MW  = mbet_pkg::MAG_W;
   localparam int PW  = mbet_pkg::PROD_W;
   localparam int XW  = mbet_pkg::COORD_W;
   localparam int NW  = mbet_pkg::COUNT_W;
   localparam int FB  = mbet_pkg::FRAC_BITS;
   localparam int SW  = CW + XW + 3;   // width of origin + index * step

   // Configuration registers
   logic [CW-1:0] origin_re_ff, origin_im_ff, step_re_ff, step_im_ff;
   logic [NW-1:0] limit_ff;

   // Sequencer and working registers
   logic [2:0]    state_ff, state_in;
   logic [XW-1:0] px_ff, px_in, py_ff, py_in;
   logic [CW-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic [ZW-1:0] z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] prod_ff [3];
   logic [PW-1:0] prod_in [3];

   // Response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [71:0]   rsp_data_ff, rsp_data_in;

   // Multiplier operands
   logic [MW-1:0] op_a [3];
   logic [MW-1:0] op_b [3];
   logic [ZW-1:0] z_re_abs, z_im_abs;
   logic [CW-1:0] step_re_abs, step_im_abs;

   // Setup arithmetic
   logic [SW-1:0] prod_re_s, prod_im_s, sum_re, sum_im;
   logic [CW-1:0] c_re_sat, c_im_sat, c_im_abs;

   // Iteration arithmetic
   logic [ZW-1:0] xs, ys;
   logic [ZW:0]   tp, mag_sum;
   logic [ZW+1:0] tp_s, zr_next, zi_next;
   logic          keep_going, out_free;
   mbet_pkg::rgb_type color;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff <= mbet_pkg::ORIGIN_REAL_RST;
         origin_im_ff <= mbet_pkg::ORIGIN_IMAG_RST;
         step_re_ff   <= mbet_pkg::STEP_REAL_RST;
         step_im_ff   <= mbet_pkg::STEP_IMAG_RST;
         limit_ff     <= mbet_pkg::LIMIT_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            mbet_pkg::CSR_ORIGIN_REAL: origin_re_ff <= csr_wdata;
            mbet_pkg::CSR_ORIGIN_IMAG: origin_im_ff <= csr_wdata;
            mbet_pkg::CSR_STEP_REAL:   step_re_ff   <= csr_wdata;
            mbet_pkg::CSR_STEP_IMAG:   step_im_ff   <= csr_wdata;
            mbet_pkg::CSR_LIMIT_COUNT: limit_ff     <= csr_wdata[NW-1:0];
            default: ;
         endcase
      end
   end

   // Feed the shared multipliers: index * |step| during setup, the products for z*z otherwise
   always_comb begin
      step_re_abs = step_re_ff[CW-1] ? -step_re_ff : step_re_ff;
      step_im_abs = step_im_ff[CW-1] ? -step_im_ff : step_im_ff;
      z_re_abs    = z_re_ff[ZW-1] ? -z_re_ff : z_re_ff;
      z_im_abs    = z_im_ff[ZW-1] ? -z_im_ff : z_im_ff;
      if (state_ff == S_MUL_C) begin
         op_a[0] = MW'(px_ff);
         op_b[0] = step_re_abs;
         op_a[1] = MW'(py_ff);
         op_b[1] = step_im_abs;
         op_a[2] = '0;
         op_b[2] = '0;
      end else begin
         op_a[0] = z_re_abs[MW-1:0];
         op_b[0] = z_re_abs[MW-1:0];
         op_a[1] = z_im_abs[MW-1:0];
         op_b[1] = z_im_abs[MW-1:0];
         op_a[2] = z_re_abs[MW-1:0];
         op_b[2] = z_im_abs[MW-1:0];
      end
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = op_a[i] * op_b[i];
      end
   end

   // Form c with saturation and snap the imaginary part onto the axis
   always_comb begin
      prod_re_s = step_re_ff[CW-1] ? -SW'(prod_ff[0][SW-3:0]) : SW'(prod_ff[0][SW-3:0]);
      prod_im_s = step_im_ff[CW-1] ? -SW'(prod_ff[1][SW-3:0]) : SW'(prod_ff[1][SW-3:0]);
      sum_re    = {{(SW-CW){origin_re_ff[CW-1]}}, origin_re_ff} + prod_re_s;
      sum_im    = {{(SW-CW){origin_im_ff[CW-1]}}, origin_im_ff} + prod_im_s;
      if ((&sum_re[SW-1:CW-1]) || !(|sum_re[SW-1:CW-1])) begin
         c_re_sat = sum_re[CW-1:0];
      end else begin
         c_re_sat = sum_re[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
      if ((&sum_im[SW-1:CW-1]) || !(|sum_im[SW-1:CW-1])) begin
         c_im_sat = sum_im[CW-1:0];
      end else begin
         c_im_sat = sum_im[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
      c_im_abs = c_im_sat[CW-1] ? -c_im_sat : c_im_sat;
   end

   // Truncate the products, test for escape and form the next z
   always_comb begin
      xs         = prod_ff[0][PW-1:FB];
      ys         = prod_ff[1][PW-1:FB];
      tp         = prod_ff[2][PW-1:FB-1];
      mag_sum    = {1'b0, xs} + {1'b0, ys};
      keep_going = (cnt_ff < limit_ff) && (mag_sum < mbet_pkg::ESCAPE_LIMIT);
      tp_s       = (z_re_ff[ZW-1] ^ z_im_ff[ZW-1]) ? -{1'b0, tp} : {1'b0, tp};
      zr_next    = {2'b00, xs} - {2'b00, ys} + {{(ZW+2-CW){c_re_ff[CW-1]}}, c_re_ff};
      zi_next    = tp_s + {{(ZW+2-CW){c_im_ff[CW-1]}}, c_im_ff};
      if (cnt_ff == limit_ff) begin
         color = mbet_pkg::PALETTE[mbet_pkg::PALETTE_SIZE];
      end else begin
         color = mbet_pkg::PALETTE[{1'b0, cnt_ff[mbet_pkg::PAL_IDX_W-1:0]}];
      end
   end

   // Sequence one pixel through setup and iteration
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      z_re_in      = z_re_ff;
      z_im_in      = z_im_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               px_in    = req_tdata[XW-1:0];
               py_in    = req_tdata[2*XW-1:XW];
               state_in = S_MUL_C;
            end
         end
         S_MUL_C: begin
            state_in = S_ADD_C;
         end
         S_ADD_C: begin
            c_re_in = c_re_sat;
            if ($signed({1'b0, c_im_abs, 1'b0}) <
                $signed({{2{step_im_ff[CW-1]}}, step_im_ff})) begin
               c_im_in = '0;
            end else begin
               c_im_in = c_im_sat;
            end
            z_re_in  = '0;
            z_im_in  = '0;
            cnt_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (keep_going) begin
               z_re_in  = zr_next[ZW-1:0];
               z_im_in  = zi_next[ZW-1:0];
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_MUL;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, py_ff, px_ff, color[7:0], color[15:8],
                               color[23:16], cnt_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold working values and products
   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      c_re_ff     <= c_re_in;
      c_im_ff     <= c_im_in;
      z_re_ff     <= z_re_in;
      z_im_ff     <= z_im_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= prod_in[i];
      end
   end

`ifndef SYNTHESIS
   // Setup always starts the iteration from zero
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADD_C |=> z_re_ff == '0 && z_im_ff == '0 && cnt_ff == '0)
      else $error("iteration did not start from zero");

   // The multiply step follows setup or a continuing escape test only
   a_mul_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> $past(state_ff) == S_ADD_C || $past(state_ff) == S_CHK)
      else $error("multiply step entered from wrong state");

   // Each pass round the loop adds exactly one to the count
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL && $past(state_ff) == S_CHK |-> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("iteration count did not advance by one");

   // A response is loaded only when a pixel finishes
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_CHK && state_ff == S_IDLE)
      else $error("response loaded outside the escape test");
`endif

endmodule

### sim/tb_mandelbrot_escape_time_pixel_core.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_pixel_core;

   // Register values after reset
   localparam int          DEF_ORIGIN_RE = -671088640;
   localparam int          DEF_ORIGIN_IM = -536870912;
   localparam int          DEF_STEP      = 1048576;
   localparam logic [15:0] DEF_LIMIT     = 16'd200;

   // 4.0 with 28 fraction bits
   localparam longint ESCAPE_Q = 64'sd1073741824;
   localparam int     RSP_HOLD_CYCLES = 3000;
   localparam int     RANDOM_PHASES = 12;
   localparam int     PIXELS_PER_PHASE = 75;

   localparam logic [23:0] GRADIENT_RGB [16] = '{
      24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
      24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
      24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
      24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
   };
   localparam logic [23:0] INTERIOR_RGB = 24'h101010;

   typedef struct packed {
      logic [mbet_pkg::COORD_W-1:0] row;
      logic [mbet_pkg::COORD_W-1:0] col;
   } pixel_coord_type;

   typedef struct packed {
      logic [mbet_pkg::COUNT_W-1:0] count;
      logic [7:0]                   red;
      logic [7:0]                   green;
      logic [7:0]                   blue;
      logic [mbet_pkg::COORD_W-1:0] col;
      logic [mbet_pkg::COORD_W-1:0] row;
   } pixel_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [31:0]                     req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [71:0]                     rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [mbet_pkg::CSR_ADDR_W-1:0] csr_index = '0;
   logic [mbet_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Local copy of the view registers
   int          org_re = DEF_ORIGIN_RE;
   int          org_im = DEF_ORIGIN_IM;
   int          stp_re = DEF_STEP;
   int          stp_im = DEF_STEP;
   logic [15:0] iter_limit = DEF_LIMIT;

   pixel_coord_type  pixel_pending_q[$];
   pixel_result_type pixel_expect_q[$];
   int               pixels_queued = 0;
   int               pixels_checked = 0;
   int               error_count = 0;
   logic             idling_on = 1'b1;
   int               long_hold_asks = 0;
   int               long_hold_served = 0;
   int               rsp_hold_left = 0;
   int               rsp_gap_left = 0;
   int               req_gap_left = 0;

   mandelbrot_escape_time_pixel_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Clamp to the signed 32-bit Q4.28 range
   function automatic longint sat_q4_28(input longint v);
      if (v > 64'sd2147483647)
         return 64'sd2147483647;
      if (v < -64'sd2147483648)
         return -64'sd2147483648;
      return v;
   endfunction

   // Escape-time count and colour of one pixel under the current view
   function automatic pixel_result_type escape_pixel(
         input logic [mbet_pkg::COORD_W-1:0] px,
         input logic [mbet_pkg::COORD_W-1:0] py);
      longint           c_re, c_im, zr, zi, xs, ys;
      longint unsigned  mr, mi, prod;
      logic             neg;
      int               n;
      logic [23:0]      rgb;
      pixel_result_type r;
      c_re = sat_q4_28(longint'(org_re) + longint'(px) * longint'(stp_re));
      c_im = sat_q4_28(longint'(org_im) + longint'(py) * longint'(stp_im));
      // snap the imaginary part to the axis within half a row step
      if (2 * (c_im < 0 ? -c_im : c_im) < longint'(stp_im))
         c_im = 0;
      zr = 0;
      zi = 0;
      xs = 0;
      ys = 0;
      n = 0;
      while (n < iter_limit && xs + ys < ESCAPE_Q) begin
         mr = zr < 0 ? -zr : zr;
         mi = zi < 0 ? -zi : zi;
         neg = (zr < 0) != (zi < 0);
         prod = (mr * mi) >> (mbet_pkg::FRAC_BITS - 1);
         zi = (neg ? -longint'(prod) : longint'(prod)) + c_im;
         zr = xs - ys + c_re;
         mr = zr < 0 ? -zr : zr;
         mi = zi < 0 ? -zi : zi;
         xs = longint'((mr * mr) >> mbet_pkg::FRAC_BITS);
         ys = longint'((mi * mi) >> mbet_pkg::FRAC_BITS);
         n++;
      end
      rgb = (n == iter_limit) ? INTERIOR_RGB : GRADIENT_RGB[n[3:0]];
      r.count = n[mbet_pkg::COUNT_W-1:0];
      r.red   = rgb[23:16];
      r.green = rgb[15:8];
      r.blue  = rgb[7:0];
      r.col   = px;
      r.row   = py;
      return r;
   endfunction

   // Write one register; the write lands at the next rising edge
   task automatic write_reg(input logic [mbet_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         mbet_pkg::CSR_ORIGIN_REAL: org_re = data;
         mbet_pkg::CSR_ORIGIN_IMAG: org_im = data;
         mbet_pkg::CSR_STEP_REAL:   stp_re = data;
         mbet_pkg::CSR_STEP_IMAG:   stp_im = data;
         mbet_pkg::CSR_LIMIT_COUNT: iter_limit = data[15:0];
         default: ;
      endcase
   endtask

   // Program the whole view, with junk in the unused upper bits of the limit
   task automatic set_view(input int ore, input int oim, input int sre, input int sim,
                           input logic [15:0] lim);
      write_reg(mbet_pkg::CSR_ORIGIN_REAL, ore);
      write_reg(mbet_pkg::CSR_ORIGIN_IMAG, oim);
      write_reg(mbet_pkg::CSR_STEP_REAL, sre);
      write_reg(mbet_pkg::CSR_STEP_IMAG, sim);
      write_reg(mbet_pkg::CSR_LIMIT_COUNT, {16'($urandom()), lim});
      csr_we <= 1'b0;
   endtask

   task automatic queue_pixel(input int x, input int y);
      pixel_coord_type p;
      p.col = x[mbet_pkg::COORD_W-1:0];
      p.row = y[mbet_pkg::COORD_W-1:0];
      pixel_pending_q.push_back(p);
      pixels_queued++;
   endtask

   // Hold the sender until every queued pixel has come back
   task automatic wait_drained();
      while (pixels_checked != pixels_queued)
         @(posedge clock);
   endtask

   // Request driver: present queued pixels with random gaps
   always @(posedge clock) begin : req_drive
      pixel_coord_type p;
      if (reset) begin
         req_tvalid   <= 1'b0;
         req_gap_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap_left != 0) begin
            req_gap_left <= req_gap_left - 1;
            req_tvalid   <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            req_gap_left <= $urandom_range(0, 2);
            req_tvalid   <= 1'b0;
         end else if (pixel_pending_q.size() != 0) begin
            p = pixel_pending_q.pop_front();
            req_tdata  <= {4'b0, p.row, p.col};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response ready: long hold-off on request, otherwise short random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready    <= 1'b0;
         rsp_hold_left <= 0;
         rsp_gap_left  <= 0;
      end else if (long_hold_asks != long_hold_served) begin
         long_hold_served <= long_hold_served + 1;
         rsp_hold_left    <= RSP_HOLD_CYCLES;
         rsp_tready       <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready    <= 1'b0;
      end else if (rsp_gap_left != 0) begin
         rsp_gap_left <= rsp_gap_left - 1;
         rsp_tready   <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         rsp_gap_left <= $urandom_range(0, 2);
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each response against the oldest prediction, then predict new requests
   always @(posedge clock) begin : pixel_monitor
      pixel_result_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.count = rsp_tdata[15:0];
            got.red   = rsp_tdata[23:16];
            got.green = rsp_tdata[31:24];
            got.blue  = rsp_tdata[39:32];
            got.col   = rsp_tdata[53:40];
            got.row   = rsp_tdata[67:54];
            if (pixel_expect_q.size() == 0) begin
               $error("unexpected response: iteration_count %0d echo_x %0d echo_y %0d",
                      got.count, got.col, got.row);
               error_count++;
            end else begin
               want = pixel_expect_q.pop_front();
               if (got.count !== want.count) begin
                  $error("iteration_count: expected %0d, got %0d", want.count, got.count);
                  error_count++;
               end
               if (got.red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, got.red);
                  error_count++;
               end
               if (got.green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, got.green);
                  error_count++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, got.blue);
                  error_count++;
               end
               if (got.col !== want.col) begin
                  $error("echo_x: expected %0d, got %0d", want.col, got.col);
                  error_count++;
               end
               if (got.row !== want.row) begin
                  $error("echo_y: expected %0d, got %0d", want.row, got.row);
                  error_count++;
               end
               pixels_checked++;
            end
         end
         if (req_tvalid && req_tready)
            pixel_expect_q.push_back(escape_pixel(req_tdata[13:0], req_tdata[27:14]));
      end
   end

   initial begin
      int          ph, k, ore, oim, sre, sim;
      logic [15:0] lim;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset view: image corners, a point on the real axis and one point off it
      queue_pixel(0, 0);
      queue_pixel(16383, 16383);
      queue_pixel(16383, 0);
      queue_pixel(0, 16383);
      queue_pixel(480, 512);
      queue_pixel(300, 600);
      wait_drained();

      // imaginary part just inside half a step snaps to the axis; one row off does not
      set_view(DEF_ORIGIN_RE, DEF_ORIGIN_IM + 524287, DEF_STEP, DEF_STEP, DEF_LIMIT);
      queue_pixel(352, 512);
      queue_pixel(352, 511);
      wait_drained();

      // exactly half a step: no snap
      set_view(DEF_ORIGIN_RE, DEF_ORIGIN_IM + 524288, DEF_STEP, DEF_STEP, DEF_LIMIT);
      queue_pixel(352, 512);
      wait_drained();

      // negative row step never snaps
      set_view(DEF_ORIGIN_RE, 100, DEF_STEP, -DEF_STEP, DEF_LIMIT);
      queue_pixel(352, 0);
      queue_pixel(352, 1);
      wait_drained();

      // saturation of c at both ends
      set_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
      queue_pixel(16383, 16383);
      wait_drained();
      set_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd1);
      queue_pixel(16383, 16383);
      queue_pixel(0, 0);
      wait_drained();

      // zero limit: no iteration, interior colour
      set_view(DEF_ORIGIN_RE, DEF_ORIGIN_IM, DEF_STEP, DEF_STEP, 16'd0);
      queue_pixel(480, 512);
      queue_pixel(0, 0);
      wait_drained();

      // c = 0 at the largest limit runs the full count
      set_view(0, 0, 0, 0, 16'hFFFF);
      queue_pixel(0, 0);
      wait_drained();

      // writes beyond the register list must leave the view alone
      set_view(DEF_ORIGIN_RE, DEF_ORIGIN_IM, DEF_STEP, DEF_STEP, 16'd17);
      for (k = int'(mbet_pkg::CSR_LIMIT_COUNT) + 1; k < 2 ** mbet_pkg::CSR_ADDR_W; k++)
         write_reg(k[mbet_pkg::CSR_ADDR_W-1:0], $urandom());
      csr_we <= 1'b0;
      queue_pixel(480, 512);
      queue_pixel(0, 0);
      wait_drained();

      // random views: mostly windows around the set, every fourth one pure noise
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph % 4 == 3) begin
            ore = $urandom();
            oim = $urandom();
            sre = $urandom();
            sim = $urandom();
            lim = 16'($urandom_range(1, 300));
         end else begin
            ore = DEF_ORIGIN_RE + int'($urandom_range(0, 268435456));
            oim = -335544320 + int'($urandom_range(0, 268435456));
            sre = $urandom_range(0, 1) ? $urandom_range(1, 65536) : $urandom_range(1, 4096);
            sim = $urandom_range(0, 1) ? $urandom_range(1, 65536) : $urandom_range(1, 4096);
            lim = 16'($urandom_range(16, 300));
         end
         // fast pixels while the receiver holds off, so the core backs up
         if (ph == 1)
            lim = 16'($urandom_range(2, 8));
         set_view(ore, oim, sre, sim, lim);
         if (ph == 1)
            long_hold_asks <= long_hold_asks + 1;
         // no idling on either side at the end of the run
         if (ph == RANDOM_PHASES - 2)
            idling_on <= 1'b0;
         for (k = 0; k < PIXELS_PER_PHASE; k++) begin
            if ($urandom_range(0, 7) == 0)
               queue_pixel($urandom_range(0, 1) * 16383, $urandom_range(0, 1) * 16383);
            else
               queue_pixel($urandom_range(0, 16383), $urandom_range(0, 16383));
         end
         wait_drained();
      end

      // let any stray response show up
      repeat (600) @(posedge clock);
      if (pixel_expect_q.size() != 0) begin
         $error("%0d predicted pixels never returned", pixel_expect_q.size());
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
sv/mbet_pkg.sv
sv/mandelbrot_escape_time_pixel_core.sv
sim/tb_mandelbrot_escape_time_pixel_core.sv
